[design/dws_pkg.sv]
// Shared types and constants for the deque with search.
// No dependencies; dws_if, dws_front, dws_back and deque_with_search use this package.
`default_nettype none

package dws_pkg;

    localparam int OP_W   = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int ST_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_DUMP       = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOMATCH = 2'd3
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } bk_state_t;

    typedef struct packed {
        op_t                      op;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

[design/dws_if.sv]
// Valid/ready channel interfaces for the request and result sides.
// Depends on dws_pkg for field widths.
`default_nettype none

interface dws_req_if;
    logic                               valid;
    logic                               ready;
    logic [dws_pkg::OP_W-1:0]           operation;
    logic signed [dws_pkg::DATA_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface dws_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [dws_pkg::ST_W-1:0]           status;
    logic [dws_pkg::POS_W-1:0]          position;
    logic signed [dws_pkg::DATA_W-1:0]  data;
    logic                               last;

    modport source (output valid, output status, output position, output data,
                    output last, input ready);
    modport sink   (input valid, input status, input position, input data,
                    input last, output ready);
endinterface

`default_nettype wire

[design/dws_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/dws_front.sv]
// Front end: takes request items, drops unused operation codes and queues the rest.
// Depends on dws_pkg and dws_if.
`default_nettype none

module dws_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    dws_req_if.sink         req,
    output logic            cmd_valid,
    output dws_pkg::cmd_t   cmd,
    input  wire logic       cmd_ready
);
    import dws_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int QP_W        = $clog2(QUEUE_DEPTH);
    localparam int QF_W        = $clog2(QUEUE_DEPTH + 1);

    cmd_t            q_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_sel_reg, wr_sel_next;
    logic [QP_W-1:0] rd_sel_reg, rd_sel_next;
    logic [QF_W-1:0] fill_reg, fill_next;
    logic            keep;
    logic            take;

    assign req.ready = (fill_reg != QF_W'(QUEUE_DEPTH));
    assign keep      = req.valid && req.ready
                       && (req.operation inside {[OP_PUSH_FRONT:OP_DUMP]});
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_sel_reg];
    assign take      = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_sel_next = wr_sel_reg;
        rd_sel_next = rd_sel_reg;
        fill_next   = fill_reg;
        if (keep)
        begin
            wr_sel_next = (wr_sel_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_sel_reg + 1'b1;
        end
        if (take)
        begin
            rd_sel_next = (rd_sel_reg == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_sel_reg + 1'b1;
        end
        case ({keep, take})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= '0;
            rd_sel_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            q_reg[wr_sel_reg] <= '{op: op_t'(req.operation), value: req.value};
        end
    end

endmodule

`default_nettype wire

[design/dws_back.sv]
// Back end: ring state, entry RAM and the sequencer for push, pop, search and dump.
// Depends on dws_pkg, dws_if and dws_ram.
`default_nettype none

module dws_back #(
    parameter int DEPTH = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire dws_pkg::cmd_t  cmd,
    output logic                cmd_ready,
    dws_rsp_if.source           rsp
);
    import dws_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    bk_state_t                state_reg, state_next;
    logic [IW-1:0]            front_reg, front_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [IW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            issued_reg, issued_next;
    logic                     b_valid_reg, b_valid_next;
    logic [IW-1:0]            b_off_reg, b_off_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic                     dump_reg, dump_next;

    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg, out_status_next;
    logic [POS_W-1:0]         out_pos_reg, out_pos_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    logic                     wr_en;
    logic [IW-1:0]            wr_addr;
    logic                     rd_en;
    logic [DATA_W-1:0]        rd_data;

    logic                     out_free;
    logic                     full;
    logic                     empty;
    logic [SW-1:0]            tail_sum;
    logic [SW-1:0]            tail_idx;
    logic [IW-1:0]            front_dec;
    logic                     b_last;
    logic                     consume;
    logic                     issue;

    dws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    assign out_free  = !out_valid_reg || rsp.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign tail_sum  = SW'(front_reg) + SW'(count_reg);
    assign tail_idx  = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
    assign front_dec = (front_reg == '0) ? IW'(DEPTH - 1) : front_reg - 1'b1;
    assign b_last    = (CW'(b_off_reg) == count_reg - 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        issued_next     = issued_reg;
        b_valid_next    = b_valid_reg;
        b_off_next      = b_off_reg;
        key_next        = key_reg;
        dump_next       = dump_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        wr_en           = 1'b0;
        wr_addr         = front_dec;
        rd_en           = 1'b0;
        cmd_ready       = 1'b0;
        consume         = 1'b0;
        issue           = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                cmd_ready = out_free;
                if (cmd_valid && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_pos_next    = '0;
                    out_data_next   = '0;
                    out_last_next   = 1'b1;
                    case (cmd.op)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = tail_idx[IW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                front_next = (front_reg == IW'(DEPTH - 1)) ? '0
                                             : front_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        OP_SEARCH, OP_DUMP:
                        begin
                            if (empty)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_valid_next = 1'b0;
                                state_next     = BK_SCAN;
                                ptr_next       = front_reg;
                                issued_next    = '0;
                                b_valid_next   = 1'b0;
                                key_next       = cmd.value;
                                dump_next      = (cmd.op == OP_DUMP);
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            BK_SCAN:
            begin
                consume = b_valid_reg && (out_free || !dump_reg);
                issue   = (issued_reg != count_reg) && (!b_valid_reg || consume);
                if (issue)
                begin
                    rd_en       = 1'b1;
                    ptr_next    = (ptr_reg == IW'(DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    issued_next = issued_reg + 1'b1;
                    b_off_next  = issued_reg[IW-1:0];
                end
                b_valid_next = issue || (b_valid_reg && !consume);
                if (consume)
                begin
                    if (dump_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_OK;
                        out_pos_next    = '0;
                        out_data_next   = rd_data;
                        out_last_next   = b_last;
                        if (b_last)
                        begin
                            state_next   = BK_IDLE;
                            b_valid_next = 1'b0;
                        end
                    end
                    else if ((rd_data == key_reg) || b_last)
                    begin
                        out_valid_next  = 1'b1;
                        out_data_next   = '0;
                        out_last_next   = 1'b1;
                        state_next      = BK_IDLE;
                        b_valid_next    = 1'b0;
                        if (rd_data == key_reg)
                        begin
                            out_status_next = ST_OK;
                            out_pos_next    = POS_W'(b_off_reg) + POS_W'(1);
                        end
                        else
                        begin
                            out_status_next = ST_NOMATCH;
                            out_pos_next    = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            issued_reg    <= '0;
            b_valid_reg   <= 1'b0;
            b_off_reg     <= '0;
            dump_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            issued_reg    <= issued_next;
            b_valid_reg   <= b_valid_next;
            b_off_reg     <= b_off_next;
            dump_reg      <= dump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.status   = out_status_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.data     = out_data_reg;
    assign rsp.last     = out_last_reg;

endmodule

`default_nettype wire

[design/deque_with_search.sv]
// Deque with search: bounded double-ended queue of signed 32-bit values in a ring of DEPTH.
// Push and pop: front queue, then registered result; one item per cycle while rsp.ready is high.
// Search: scans from the front to the first match, or to the last entry with no match;
// dump: one result per entry, one per cycle while rsp.ready is high, via the RAM read port.
// Reset (rst_n, asynchronous, active low) empties the deque; the entry RAM is not cleared.
// Depends on dws_pkg, dws_if, dws_ram, dws_front and dws_back.
`default_nettype none

module deque_with_search #(
    parameter int DEPTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dws_req_if.sink     req,
    dws_rsp_if.source   rsp
);
    import dws_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    dws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    dws_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

    a_queue_ops_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (cmd.op <= OP_DUMP))
        else $error("unused operation code reached the back end");

    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |-> (rsp.last && (rsp.data == '0)))
        else $error("error result not final or carries data");

    a_position_only_on_match: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.position != '0)) |->
            ((rsp.status == ST_OK) && rsp.last && (rsp.data == '0)))
        else $error("position reported outside a search match");

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.position <= POS_W'(DEPTH)))
        else $error("position beyond deque depth");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// Testbench for deque_with_search: directed corner cases, then random operation mixes.
// A scoreboard class predicts every result item and checks them in order.
// Depends on dws_pkg, dws_if and the design files under design/.

module testbench;
    import dws_pkg::*;

    localparam int DEPTH        = 16;
    localparam int BLOCKS       = 12;
    localparam int BLOCK_ITEMS  = 30;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 50;
    localparam int LONG_HOLD    = 300;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } result_t;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] ring [DEPTH];
        logic [3:0]               front;
        logic [4:0]               count;
        result_t                  awaited [$];
        int                       errors;

        function new();
            front  = '0;
            count  = '0;
            errors = 0;
            foreach (ring[i])
                ring[i] = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic signed [DATA_W-1:0] stored_at(int offset);
            logic [3:0] slot;
            slot = front + offset[3:0];
            return ring[slot];
        endfunction

        function void add_result(status_t st, int pos, logic signed [DATA_W-1:0] d, logic l);
            result_t r;
            r.status   = st;
            r.position = pos[POS_W-1:0];
            r.data     = d;
            r.last     = l;
            awaited.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10)
                $display("%s", msg);
        endfunction

        // Accepted request item: update the deque copy and queue its results.
        function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
            logic [3:0] slot;
            int         hit;
            case (op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (count == DEPTH)
                        add_result(ST_FULL, 0, '0, 1'b1);
                    else
                    begin
                        if (op == OP_PUSH_FRONT)
                        begin
                            front = front - 4'd1;
                            slot  = front;
                        end
                        else
                            slot = front + count[3:0];
                        ring[slot] = val;
                        count++;
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    if (count == 0)
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    else
                    begin
                        if (op == OP_POP_FRONT)
                            front = front + 4'd1;
                        count--;
                        add_result(ST_OK, 0, '0, 1'b1);
                    end
                end
                OP_SEARCH:
                begin
                    if (count == 0)
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    else
                    begin
                        hit = 0;
                        for (int i = 0; i < count; i++)
                        begin
                            if (hit == 0 && stored_at(i) == val)
                                hit = i + 1;
                        end
                        if (hit != 0)
                            add_result(ST_OK, hit, '0, 1'b1);
                        else
                            add_result(ST_NOMATCH, 0, '0, 1'b1);
                    end
                end
                OP_DUMP:
                begin
                    if (count == 0)
                        add_result(ST_EMPTY, 0, '0, 1'b1);
                    else
                        for (int i = 0; i < count; i++)
                            add_result(ST_OK, 0, stored_at(i), i == count - 1);
                end
                default:
                    ;   // spare codes: ignored
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result item: status %0d position %0d data %0d last %0d",
                                 got.status, got.position, got.data, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.position !== want.position ||
                got.data !== want.data || got.last !== want.last)
                report($sformatf({"result mismatch: expected status %0d position %0d data %0d ",
                                  "last %0d, got status %0d position %0d data %0d last %0d"},
                                 want.status, want.position, want.data, want.last,
                                 got.status, got.position, got.data, got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    dws_req_if req ();
    dws_rsp_if rsp ();

    deque_scoreboard board = new();

    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int cycle_count = 0;

    deque_with_search #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, plus one long hold when asked.
    initial
    begin
        int stall;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            @(negedge clk);
            if (rx_hold > 0)
            begin
                stall   = rx_hold;
                rx_hold = 0;
            end
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got.status   = rsp.status;
            got.position = rsp.position;
            got.data     = rsp.data;
            got.last     = rsp.last;
            board.check_result(got);
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid     <= 1'b1;
        req.operation <= op;
        req.value     <= val;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(op, val);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        req.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return $urandom;
        if (r < 7)
            case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'sd0;
                3: return -32'sd1;
                default: return 32'sd1;
            endcase
        return $signed($urandom_range(0, 7)) - 32'sd3;
    endfunction

    // One random item; returns 0 for a spare code, which the block ignores.
    task automatic random_item(input int mode, output bit counted);
        int                       r;
        int                       push_w;
        int                       pop_w;
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        push_w = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 15 : 33;
        pop_w  = (mode == MODE_FILL) ? 12 : (mode == MODE_DRAIN) ? 50 : 30;
        r      = $urandom_range(0, 99);
        if (r < push_w)
            op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (r < push_w + pop_w)
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        else if (r < 92)
            op = OP_SEARCH;
        else if (r < 98)
            op = OP_DUMP;
        else
            op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
        if (op == OP_SEARCH && board.count != 0 && $urandom_range(0, 9) < 6)
            val = board.stored_at($urandom_range(0, board.count - 1));
        else
            val = pick_value();
        send_item(op, val);
        counted = (op != OP_SPARE_6 && op != OP_SPARE_7);
    endtask

    task automatic random_block(input int mode, input int n);
        int done;
        bit counted;
        done = 0;
        while (done < n)
        begin
            random_item(mode, counted);
            if (counted)
                done++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.operation = OP_PUSH_FRONT;
        req.value     = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // empty deque on pops, search and dump, spare codes, extreme values
        send_item(OP_DUMP, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_SPARE_6, -32'sd1);
        send_item(OP_SPARE_7, VAL_MAX);
        send_item(OP_PUSH_FRONT, VAL_MIN);
        send_item(OP_PUSH_BACK, VAL_MAX);
        send_item(OP_PUSH_FRONT, -32'sd1);
        send_item(OP_PUSH_BACK, 32'sd0);
        send_item(OP_SEARCH, VAL_MAX);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_SEARCH, 32'sd12345);
        send_item(OP_DUMP, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        send_item(OP_POP_BACK, 32'sd0);
        send_item(OP_DUMP, 32'sd0);
        send_item(OP_POP_FRONT, 32'sd0);
        wait_quiet();

        // long result hold while items keep coming: fills to full, overflows, backs up
        tx_idle = 1'b0;
        rx_hold = LONG_HOLD;
        repeat (18) send_item(OP_PUSH_BACK, pick_value());
        random_block(MODE_MIXED, 22);
        wait_quiet();

        for (int b = 0; b < BLOCKS; b++)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            random_block(b % 3, BLOCK_ITEMS);
            if ($urandom_range(0, 2) == 0)
                wait_quiet();
        end

        wait_quiet();
        if (board.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
